>>> hw/rtl/sob_pkg.sv
package sob_pkg;

	localparam logic [7:0]  CH_MAX     = 8'd255;
	localparam logic [16:0] ROUND_BIAS = 17'd128;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;
	localparam int NUM_CH   = 4;

	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_OPACITY = 1'b0;

	typedef logic [NUM_CH-1:0][7:0] pixel_t;

	typedef struct packed {
		pixel_t src;
		pixel_t dst;
		logic   span_end;
	} beat_t;

	typedef struct packed {
		pixel_t src;
		pixel_t scaled;
		pixel_t dst;
		logic   opaque;
		logic   span_end;
	} mid_t;

	function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
		return 16'(a) * 16'(b);
	endfunction

	function automatic logic [7:0] div255_round(input logic [15:0] v);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, v} + ROUND_BIAS;
		u = t + {8'b0, t[16:8]};
		return u[15:8];
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? CH_MAX : s[7:0];
	endfunction

endpackage

>>> hw/rtl/sob_src_scale.sv
module sob_src_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    opacity,
	input  logic          in_valid,
	output logic          in_ready,
	input  sob_pkg::beat_t in_beat,
	output logic          out_valid,
	input  logic          out_ready,
	output sob_pkg::mid_t out_mid
);
	import sob_pkg::*;

	logic        v_s1;
	beat_t       beat_s1;
	logic [15:0] sprod_s1 [NUM_CH];
	logic        opaque_s1;
	logic        v_s2;
	mid_t        mid_s2;
	logic        en_s1;
	logic        en_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			beat_s1   <= in_beat;
			opaque_s1 <= (opacity == CH_MAX);
			for (int c = 0; c < NUM_CH; c++) begin
				sprod_s1[c] <= mul8(in_beat.src[c], opacity);
			end
		end
		if (en_s2 && v_s1) begin
			mid_s2.src      <= beat_s1.src;
			mid_s2.dst      <= beat_s1.dst;
			mid_s2.opaque   <= opaque_s1;
			mid_s2.span_end <= beat_s1.span_end;
			for (int c = 0; c < NUM_CH; c++) begin
				mid_s2.scaled[c] <= div255_round(sprod_s1[c]);
			end
		end
	end

	assign out_valid = v_s2;
	assign out_mid   = mid_s2;

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en_s2 |=> v_s2)
		else $error("stage 1 beat lost on advance");

	a_full_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en_s2 && opaque_s1 && beat_s1.src[CH_ALPHA] == CH_MAX
		|=> mid_s2.scaled[CH_ALPHA] == CH_MAX)
		else $error("full alpha at full opacity not preserved");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(mid_s2))
		else $error("stage 2 changed while stalled");

endmodule

>>> hw/rtl/sob_dst_mix.sv
module sob_dst_mix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sob_pkg::mid_t  in_mid,
	output logic           out_valid,
	input  logic           out_ready,
	output sob_pkg::pixel_t out_pixel,
	output logic           out_span_end
);
	import sob_pkg::*;

	logic        v_s3;
	mid_t        mid_s3;
	logic [15:0] dprod_s3 [NUM_CH];
	logic        v_s4;
	pixel_t      pix_s4;
	logic        span_s4;
	logic        en_s3;
	logic        en_s4;
	logic [7:0]  inv_a;
	logic [7:0]  eff_a;
	pixel_t      blend;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;
	assign inv_a    = CH_MAX - in_mid.scaled[CH_ALPHA];
	assign eff_a    = mid_s3.scaled[CH_ALPHA];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			blend[c] = sat_add(mid_s3.scaled[c], div255_round(dprod_s3[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			mid_s3 <= in_mid;
			for (int c = 0; c < NUM_CH; c++) begin
				dprod_s3[c] <= mul8(in_mid.dst[c], inv_a);
			end
		end
		if (en_s4 && v_s3) begin
			span_s4 <= mid_s3.span_end;
			if (eff_a == 8'd0) begin
				pix_s4 <= mid_s3.dst;
			end else if (eff_a == CH_MAX && mid_s3.opaque) begin
				pix_s4 <= mid_s3.src;
			end else begin
				pix_s4 <= blend;
			end
		end
	end

	assign out_valid    = v_s4;
	assign out_pixel    = pix_s4;
	assign out_span_end = span_s4;

	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 && eff_a == 8'd0 |=> pix_s4 == $past(mid_s3.dst))
		else $error("transparent source did not pass destination");

	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 && eff_a == CH_MAX && mid_s3.opaque |=> pix_s4 == $past(mid_s3.src))
		else $error("opaque source not copied");

	a_s3_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 |=> v_s4)
		else $error("stage 3 beat lost on advance");

endmodule

>>> hw/rtl/source_over_alpha_blend_core.sv
// Source-over blend of premultiplied 8-bit RGBA pixels under a global opacity
// register (APB byte address 0, reset 255). One pixel beat is accepted every
// clock while the output is not stalled; each result passes through the two
// multiply/divide-by-255 steps (source scale, then destination weight), each
// split over two register stages. Each stage holds only while the stage after
// it is full and stalled, so bubbles close up under output backpressure.
// Write opacity only while no beat is in flight.
module source_over_alpha_blend_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sob_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  src_red,
	input  logic [7:0]                  src_green,
	input  logic [7:0]                  src_blue,
	input  logic [7:0]                  src_alpha,
	input  logic [7:0]                  dst_red,
	input  logic [7:0]                  dst_green,
	input  logic [7:0]                  dst_blue,
	input  logic [7:0]                  dst_alpha,
	input  logic                        span_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_red,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_blue,
	output logic [7:0]                  out_alpha,
	output logic                        out_span_end
);
	import sob_pkg::*;

	logic [7:0] opacity_q;
	logic [0:0] reg_idx;
	beat_t      in_beat;
	mid_t       mid;
	logic       mid_valid;
	logic       mid_ready;
	pixel_t     out_pixel;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:PADDR_W-1];
	assign prdata  = (reg_idx == REG_OPACITY) ? {24'b0, opacity_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= CH_MAX;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_OPACITY) begin
			opacity_q <= pwdata[7:0];
		end
	end

	assign in_beat.src      = {src_alpha, src_blue, src_green, src_red};
	assign in_beat.dst      = {dst_alpha, dst_blue, dst_green, dst_red};
	assign in_beat.span_end = span_end;

	sob_src_scale u_src_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.opacity   (opacity_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_beat   (in_beat),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_mid   (mid)
	);

	sob_dst_mix u_dst_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mid_valid),
		.in_ready     (mid_ready),
		.in_mid       (mid),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_pixel    (out_pixel),
		.out_span_end (out_span_end)
	);

	assign out_red   = out_pixel[CH_RED];
	assign out_green = out_pixel[CH_GREEN];
	assign out_blue  = out_pixel[CH_BLUE];
	assign out_alpha = out_pixel[CH_ALPHA];

endmodule
